// ===== src/mbp_pkg.sv =====
// shared types, constants and helpers for the midi byte stream parser
`default_nettype none

package mbp_pkg;

    localparam logic [7:0] BYTE_CLOCK      = 8'hF8;
    localparam logic [7:0] BYTE_START      = 8'hFA;
    localparam logic [7:0] BYTE_CONTINUE   = 8'hFB;
    localparam logic [7:0] BYTE_STOP       = 8'hFC;
    localparam logic [7:0] BYTE_SYSEX_ON   = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_OFF  = 8'hF7;
    localparam logic [7:0] BYTE_CHAN_LAST  = 8'hEF;
    localparam logic [7:0] BYTE_SONG_POS   = 8'hF2;
    localparam logic [7:0] BYTE_QFRAME     = 8'hF1;
    localparam logic [7:0] BYTE_SONG_SEL   = 8'hF3;
    localparam logic [7:0] BYTE_SYSTEM     = 8'hF0;
    localparam logic [7:0] BYTE_REALTIME   = 8'hF8;
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_CTRL       = 4'hB;
    localparam logic [3:0] KIND_PROGRAM    = 4'hC;
    localparam logic [3:0] KIND_PRESSURE   = 4'hD;

    localparam logic [2:0] EV_NOTE_OFF     = 3'd0;
    localparam logic [2:0] EV_NOTE_ON      = 3'd1;
    localparam logic [2:0] EV_CTRL         = 3'd2;
    localparam logic [2:0] EV_SONG_POS     = 3'd3;
    localparam logic [2:0] EV_CLOCK        = 3'd4;
    localparam logic [2:0] EV_START        = 3'd5;
    localparam logic [2:0] EV_CONTINUE     = 3'd6;
    localparam logic [2:0] EV_STOP         = 3'd7;

    typedef struct packed {
        logic [2:0]  event_type;
        logic [3:0]  channel;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic [13:0] position_value;
    } mbp_result_t;

    // data bytes that complete a message begun with this status
    function automatic logic [1:0] mbp_expected(input logic [7:0] st);
        logic [1:0] cnt;
        begin
            if (st[7] && st <= BYTE_CHAN_LAST)
            begin
                if (st[7:4] == KIND_PROGRAM || st[7:4] == KIND_PRESSURE)
                    cnt = 2'd1;
                else
                    cnt = 2'd2;
            end
            else if (st == BYTE_SONG_POS)
                cnt = 2'd2;
            else if (st == BYTE_QFRAME || st == BYTE_SONG_SEL)
                cnt = 2'd1;
            else
                cnt = 2'd0;
            return cnt;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/mbp_in_stage.sv =====
// input register for received bytes
`default_nettype none

module mbp_in_stage
    import mbp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       midi_valid,
    output logic            midi_ready,
    input  wire logic [7:0] midi_byte,
    input  wire logic       space,
    output logic            step,
    output logic [7:0]      byte_out
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign step       = valid_reg && space;
    assign midi_ready = !valid_reg || step;
    assign byte_out   = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (midi_valid && midi_ready)
            valid_next = 1'b1;
        else if (step)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (midi_valid && midi_ready)
            byte_reg <= midi_byte;
    end

endmodule

`default_nettype wire

// ===== src/mbp_core.sv =====
// parser state and per-byte decode
`default_nettype none

module mbp_core
    import mbp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] byte_in,
    output logic            res_valid,
    output mbp_result_t     res
);

    logic [7:0] cur_reg;
    logic [7:0] cur_next;
    logic [7:0] run_reg;
    logic [7:0] run_next;
    logic [6:0] d0_reg;
    logic [6:0] d0_next;
    logic [6:0] d1_reg;
    logic [6:0] d1_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] exp_reg;
    logic [1:0] exp_next;
    logic       sysex_reg;
    logic       sysex_next;

    logic [7:0] cur_w;
    logic [1:0] cnt_w;
    logic [1:0] exp_w;
    logic [6:0] d0_w;
    logic [6:0] d1_w;
    logic       go;

    always_comb
    begin
        cur_next   = cur_reg;
        run_next   = run_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        sysex_next = sysex_reg;
        res_valid  = 1'b0;
        res        = '0;
        cur_w      = cur_reg;
        cnt_w      = cnt_reg;
        exp_w      = exp_reg;
        d0_w       = d0_reg;
        d1_w       = d1_reg;
        go         = 1'b0;

        if (step)
        begin
            if (byte_in == BYTE_CLOCK)
            begin
                res_valid      = 1'b1;
                res.event_type = EV_CLOCK;
            end
            else if (byte_in == BYTE_START)
            begin
                res_valid      = 1'b1;
                res.event_type = EV_START;
            end
            else if (byte_in == BYTE_CONTINUE)
            begin
                res_valid      = 1'b1;
                res.event_type = EV_CONTINUE;
            end
            else if (byte_in == BYTE_STOP)
            begin
                res_valid      = 1'b1;
                res.event_type = EV_STOP;
            end
            else if (byte_in >= BYTE_REALTIME)
            begin
                res_valid = 1'b0;
            end
            else if (byte_in[7])
            begin
                if (byte_in == BYTE_SYSEX_ON)
                begin
                    sysex_next = 1'b1;
                    run_next   = '0;
                    cnt_next   = '0;
                end
                else if (byte_in == BYTE_SYSEX_OFF)
                begin
                    sysex_next = 1'b0;
                    cur_next   = '0;
                    cnt_next   = '0;
                end
                else if (!sysex_reg)
                begin
                    cur_next = byte_in;
                    cnt_next = '0;
                    exp_next = mbp_expected(byte_in);
                    run_next = (byte_in <= BYTE_CHAN_LAST) ? byte_in : 8'h00;
                end
            end
            else if (!sysex_reg)
            begin
                go = 1'b1;
                // restart from running status when no message is open
                if (exp_reg == 2'd0)
                begin
                    if (run_reg == 8'h00)
                        go = 1'b0;
                    else
                    begin
                        cur_w = run_reg;
                        cnt_w = '0;
                        exp_w = mbp_expected(run_reg);
                    end
                end
                if (go)
                begin
                    if (cnt_w < 2'd2)
                    begin
                        if (cnt_w[0])
                            d1_w = byte_in[6:0];
                        else
                            d0_w = byte_in[6:0];
                        cnt_w = cnt_w + 2'd1;
                    end
                    d0_next = d0_w;
                    d1_next = d1_w;
                    if (cnt_w < exp_w)
                    begin
                        cur_next = cur_w;
                        cnt_next = cnt_w;
                        exp_next = exp_w;
                    end
                    else
                    begin
                        res.channel     = cur_w[3:0];
                        res.data_first  = d0_w;
                        res.data_second = d1_w;
                        if (cur_w == BYTE_SONG_POS)
                        begin
                            res_valid          = 1'b1;
                            res.event_type     = EV_SONG_POS;
                            res.position_value = {d1_w, d0_w};
                        end
                        else if (cur_w[7:4] == KIND_NOTE_OFF)
                        begin
                            res_valid      = 1'b1;
                            res.event_type = EV_NOTE_OFF;
                        end
                        else if (cur_w[7:4] == KIND_NOTE_ON)
                        begin
                            res_valid      = 1'b1;
                            res.event_type = (d1_w == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
                        end
                        else if (cur_w[7:4] == KIND_CTRL)
                        begin
                            res_valid      = 1'b1;
                            res.event_type = EV_CTRL;
                        end
                        cnt_next = '0;
                        if (cur_w >= BYTE_SYSTEM)
                        begin
                            cur_next = '0;
                            exp_next = '0;
                        end
                        else
                        begin
                            cur_next = cur_w;
                            exp_next = exp_w;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            run_reg   <= '0;
            d0_reg    <= '0;
            d1_reg    <= '0;
            cnt_reg   <= '0;
            exp_reg   <= '0;
            sysex_reg <= 1'b0;
        end
        else
        begin
            cur_reg   <= cur_next;
            run_reg   <= run_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            cnt_reg   <= cnt_next;
            exp_reg   <= exp_next;
            sysex_reg <= sysex_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mbp_out_stage.sv =====
// result register for parsed events
`default_nettype none

module mbp_out_stage
    import mbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire mbp_result_t res,
    output logic             space,
    output logic             event_valid,
    input  wire logic        event_ready,
    output mbp_result_t      result
);

    logic        valid_reg;
    logic        valid_next;
    mbp_result_t res_reg;

    assign space       = !valid_reg || event_ready;
    assign event_valid = valid_reg;
    assign result      = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (event_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

`default_nettype wire

// ===== src/midi_byte_stream_parser.sv =====
// top level of the midi byte stream parser
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  byte in  | midi_valid / midi_ready   | midi_byte
//  event    | event_valid / event_ready | event_type, channel, data_first,
//           |                           | data_second, position_value
//
//  a byte is registered, decoded combinationally against the parser state, and an
//  event lands in the result register: event_valid rises when that register loads
//  one byte per cycle sustained while event_ready is high
//  a held event stalls the decode stage, the input register still takes one byte
//  reset clears all parser state and both stage valids
`default_nettype none

module midi_byte_stream_parser
    import mbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        midi_valid,
    output logic             midi_ready,
    input  wire logic [7:0]  midi_byte,
    output logic             event_valid,
    input  wire logic        event_ready,
    output logic [2:0]       event_type,
    output logic [3:0]       channel,
    output logic [6:0]       data_first,
    output logic [6:0]       data_second,
    output logic [13:0]      position_value
);

    logic        space;
    logic        step;
    logic [7:0]  byte_q;
    logic        res_valid;
    mbp_result_t res;
    mbp_result_t result;

    mbp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .midi_valid (midi_valid),
        .midi_ready (midi_ready),
        .midi_byte  (midi_byte),
        .space      (space),
        .step       (step),
        .byte_out   (byte_q)
    );

    mbp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (byte_q),
        .res_valid (res_valid),
        .res       (res)
    );

    mbp_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (res_valid),
        .res         (res),
        .space       (space),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .result      (result)
    );

    assign event_type     = result.event_type;
    assign channel        = result.channel;
    assign data_first     = result.data_first;
    assign data_second    = result.data_second;
    assign position_value = result.position_value;

endmodule

`default_nettype wire

// ===== test/tb_midi_byte_stream_parser.sv =====
// testbench for the midi byte stream parser: directed table, then random phrases against a predictor
`timescale 1ns / 100ps

module tb_midi_byte_stream_parser;
    import mbp_pkg::*;

    localparam int HOLD_CYCLES = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_LIMIT = 500;
    localparam int NUM_ROWS    = 28;

    typedef enum logic [1:0] {FROM_MODEL, NO_EVENT, GIVEN_EVENT} row_check_t;

    typedef struct packed {
        logic [7:0]  b;
        row_check_t  check;
        mbp_result_t ev;
    } stim_row_t;

    localparam stim_row_t PLAN [0:NUM_ROWS-1] = '{
        '{8'h3C, NO_EVENT,    '0},
        '{8'hF8, GIVEN_EVENT, {EV_CLOCK, 32'd0}},
        '{8'hFA, GIVEN_EVENT, {EV_START, 32'd0}},
        '{8'hFB, GIVEN_EVENT, {EV_CONTINUE, 32'd0}},
        '{8'hFC, GIVEN_EVENT, {EV_STOP, 32'd0}},
        '{8'hF9, NO_EVENT,    '0},
        '{8'hFF, NO_EVENT,    '0},
        '{8'h90, NO_EVENT,    '0},
        '{8'h00, NO_EVENT,    '0},
        '{8'h7F, FROM_MODEL,  '0},
        '{8'h00, FROM_MODEL,  '0},
        '{8'h00, FROM_MODEL,  '0},
        '{8'h8F, NO_EVENT,    '0},
        '{8'h7F, FROM_MODEL,  '0},
        '{8'hF8, GIVEN_EVENT, {EV_CLOCK, 32'd0}},
        '{8'h7F, FROM_MODEL,  '0},
        '{8'hBA, NO_EVENT,    '0},
        '{8'h01, FROM_MODEL,  '0},
        '{8'h40, FROM_MODEL,  '0},
        '{8'hF0, NO_EVENT,    '0},
        '{8'h95, NO_EVENT,    '0},
        '{8'h12, NO_EVENT,    '0},
        '{8'hF7, NO_EVENT,    '0},
        '{8'h22, FROM_MODEL,  '0},
        '{8'h33, FROM_MODEL,  '0},
        '{8'hF2, NO_EVENT,    '0},
        '{8'h7F, FROM_MODEL,  '0},
        '{8'h7F, GIVEN_EVENT, {EV_SONG_POS, 4'h2, 7'h7F, 7'h7F, 14'h3FFF}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        midi_valid = 1'b0;
    logic        midi_ready;
    logic [7:0]  midi_byte = 8'h00;
    logic        event_valid;
    logic        event_ready = 1'b0;
    logic [2:0]  event_type;
    logic [3:0]  channel;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [13:0] position_value;

    row_check_t  row_check = FROM_MODEL;
    mbp_result_t row_event = '0;

    mbp_result_t pending_events [$];
    int          error_count = 0;
    int          items_sent = 0;
    int          stall_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    // parser state as predicted
    logic [7:0]  status_now = 8'h00;
    logic [7:0]  status_running = 8'h00;
    logic [6:0]  data_held [2] = '{7'h00, 7'h00};
    logic [1:0]  data_seen = 2'd0;
    logic [1:0]  data_needed = 2'd0;
    bit          sysex_open = 1'b0;

    midi_byte_stream_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .midi_valid     (midi_valid),
        .midi_ready     (midi_ready),
        .midi_byte      (midi_byte),
        .event_valid    (event_valid),
        .event_ready    (event_ready),
        .event_type     (event_type),
        .channel        (channel),
        .data_first     (data_first),
        .data_second    (data_second),
        .position_value (position_value)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void open_status(input logic [7:0] s);
        status_now = s;
        data_seen = 2'd0;
        if (s <= BYTE_CHAN_LAST)
        begin
            status_running = s;
            if (s[7:4] == KIND_PROGRAM || s[7:4] == KIND_PRESSURE)
                data_needed = 2'd1;
            else
                data_needed = 2'd2;
        end
        else
        begin
            status_running = 8'h00;
            case (s)
                BYTE_SONG_POS:              data_needed = 2'd2;
                BYTE_QFRAME, BYTE_SONG_SEL: data_needed = 2'd1;
                default:                    data_needed = 2'd0;
            endcase
        end
    endfunction

    task automatic parse_byte(input logic [7:0] b, output logic have, output mbp_result_t ev);
        have = 1'b0;
        ev = '0;
        case (b)
            BYTE_CLOCK:    begin have = 1'b1; ev.event_type = EV_CLOCK; end
            BYTE_START:    begin have = 1'b1; ev.event_type = EV_START; end
            BYTE_CONTINUE: begin have = 1'b1; ev.event_type = EV_CONTINUE; end
            BYTE_STOP:     begin have = 1'b1; ev.event_type = EV_STOP; end
            default:
            begin
                if (b >= BYTE_REALTIME)
                    have = 1'b0;
                else if (b[7])
                begin
                    if (b == BYTE_SYSEX_ON)
                    begin
                        sysex_open = 1'b1;
                        status_running = 8'h00;
                        data_seen = 2'd0;
                    end
                    else if (b == BYTE_SYSEX_OFF)
                    begin
                        // expected count survives on purpose
                        sysex_open = 1'b0;
                        status_now = 8'h00;
                        data_seen = 2'd0;
                    end
                    else if (!sysex_open)
                        open_status(b);
                end
                else if (!sysex_open && !(data_needed == 2'd0 && status_running == 8'h00))
                begin
                    if (data_needed == 2'd0)
                        open_status(status_running);
                    if (data_seen < 2'd2)
                    begin
                        data_held[data_seen[0]] = b[6:0];
                        data_seen++;
                    end
                    if (data_seen >= data_needed)
                    begin
                        have = 1'b1;
                        if (status_now == BYTE_SONG_POS)
                        begin
                            ev.event_type = EV_SONG_POS;
                            ev.position_value = {data_held[1], data_held[0]};
                        end
                        else if (status_now[7:4] == KIND_NOTE_OFF)
                            ev.event_type = EV_NOTE_OFF;
                        else if (status_now[7:4] == KIND_NOTE_ON)
                            ev.event_type = (data_held[1] == 7'h00) ? EV_NOTE_OFF : EV_NOTE_ON;
                        else if (status_now[7:4] == KIND_CTRL)
                            ev.event_type = EV_CTRL;
                        else
                            have = 1'b0;
                        if (have)
                        begin
                            ev.channel = status_now[3:0];
                            ev.data_first = data_held[0];
                            ev.data_second = data_held[1];
                        end
                        data_seen = 2'd0;
                        if (status_now >= BYTE_SYSTEM)
                        begin
                            status_now = 8'h00;
                            data_needed = 2'd0;
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input row_check_t chk, input mbp_result_t ev);
        midi_valid <= 1'b1;
        midi_byte <= b;
        row_check <= chk;
        row_event <= ev;
        do
            @(posedge clk);
        while (!midi_ready);
        items_sent++;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            midi_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic offer(input logic [7:0] b);
        send_byte(b, FROM_MODEL, '0);
    endtask

    task automatic send_phrase();
        int         pick;
        int         n_data;
        logic [3:0] kind;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            // channel message, status sometimes left to running status
            kind = 4'($urandom_range(8, 14));
            st = {kind, 4'($urandom_range(0, 15))};
            n_data = (kind == KIND_PROGRAM || kind == KIND_PRESSURE) ? 1 : 2;
            if ($urandom_range(0, 3) != 0)
                offer(st);
            repeat (n_data)
            begin
                if ($urandom_range(0, 9) == 0)
                    offer(BYTE_REALTIME | 8'($urandom_range(0, 7)));
                if ($urandom_range(0, 5) == 0)
                    offer(8'h00);
                else
                    offer(8'($urandom_range(0, 127)));
            end
        end
        else if (pick < 70)
        begin
            offer(8'($urandom_range(8'hF1, 8'hF6)));
            repeat ($urandom_range(0, 2)) offer(8'($urandom_range(0, 127)));
        end
        else if (pick < 78)
        begin
            offer(BYTE_SYSEX_ON);
            repeat ($urandom_range(0, 6)) offer(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0)
                offer(BYTE_SYSEX_OFF);
        end
        else if (pick < 88)
            offer(BYTE_REALTIME | 8'($urandom_range(0, 7)));
        else
            offer(8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin : scoreboard
        logic        have;
        mbp_result_t ev;
        mbp_result_t want;
        if (rst_n)
        begin
            if (event_valid && event_ready)
            begin
                if (pending_events.size() == 0)
                    report_mismatch("event with nothing pending, type", event_type, 0);
                else
                begin
                    want = pending_events.pop_front();
                    if (event_type != want.event_type)
                        report_mismatch("event_type", event_type, want.event_type);
                    if (channel != want.channel)
                        report_mismatch("channel", channel, want.channel);
                    if (data_first != want.data_first)
                        report_mismatch("data_first", data_first, want.data_first);
                    if (data_second != want.data_second)
                        report_mismatch("data_second", data_second, want.data_second);
                    if (position_value != want.position_value)
                        report_mismatch("position_value", position_value, want.position_value);
                end
            end
            if (midi_valid && midi_ready)
            begin
                parse_byte(midi_byte, have, ev);
                if (row_check == GIVEN_EVENT)
                    pending_events.push_back(row_event);
                else if (row_check == FROM_MODEL && have)
                    pending_events.push_back(ev);
            end
            if ((midi_valid && midi_ready) || (event_valid && event_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("tb_midi_byte_stream_parser failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin : receiver
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                event_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                event_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                event_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_byte(PLAN[i].b, PLAN[i].check, PLAN[i].ev);

        // sender waits for every pending event
        midi_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);

        // receiver holds off while the sender keeps offering bytes
        hold_req = 1'b1;
        while (items_sent < 130)
            send_phrase();

        midi_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);

        while (items_sent < 450)
            send_phrase();
        calm = 1'b1;
        while (items_sent < 560)
            send_phrase();

        midi_valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_events.size() != 0; k++)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (pending_events.size() != 0)
            report_mismatch("events never produced, count", pending_events.size(), 0);

        if (error_count == 0)
            $display("tb_midi_byte_stream_parser passed");
        else
            $display("tb_midi_byte_stream_parser failed");
        $finish;
    end

endmodule
